[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/gdd_pkg.sv]
package gdd_pkg;

  localparam int YEAR_BITS_DEF = 14;
  localparam int MONTH_BITS    = 4;
  localparam int DAY_BITS      = 5;
  localparam int GAP_BITS      = 23;

  localparam longint GAP_MAX = 64'sd4194303;
  localparam longint GAP_MIN = -64'sd4194304;

  localparam int CENTURY      = 100;
  localparam int QUAD_CENTURY = 400;
  localparam int DAYS_COMMON  = 365;

  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;

  typedef logic [MONTH_BITS-1:0] month_t;
  typedef logic [DAY_BITS-1:0]   day_t;
  typedef logic signed [GAP_BITS-1:0] gap_t;

  // Load enables of the three ordinal stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } gdd_adv_t;

  // Days before the month in a common year; months past December close the year
  function automatic logic [8:0] days_before_month(input month_t m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/gdd_in_if.sv]
interface gdd_in_if #(
  parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
);
  import gdd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] year_a;
  month_t               month_a;
  day_t                 day_a;
  logic [YEAR_BITS-1:0] year_b;
  month_t               month_b;
  day_t                 day_b;

  modport source (
    output valid, year_a, month_a, day_a, year_b, month_b, day_b,
    input  ready
  );

  modport sink (
    input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
    output ready
  );

endinterface

[hw/rtl/gdd_out_if.sv]
interface gdd_out_if;
  import gdd_pkg::*;

  logic valid;
  logic ready;
  gap_t day_gap;

  modport source (
    output valid, day_gap,
    input  ready
  );

  modport sink (
    input  valid, day_gap,
    output ready
  );

endinterface

[hw/rtl/gregorian_date_difference.sv]
// An accepted item passes the three ordinal stages and then the gap stage,
// whose output register holds the result until it leaves.
// Throughput: one item per cycle while the output is ready; each ordinal stage
// and the gap stage holds one item and refills as soon as its occupant moves on.
// Reset: synchronous, active low; clears every stage valid bit, payload keeps
// its value.
`include "assert_macros.svh"

module gregorian_date_difference #(
  parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gdd_in_if.sink     in_dates,
  gdd_out_if.source  out_gap
);
  import gdd_pkg::*;

  localparam int OW = YEAR_BITS + 9;
  localparam int DW = OW + 1;
  localparam int GW = (DW > GAP_BITS) ? DW : GAP_BITS;
  localparam logic signed [GW-1:0] GMAX = GW'(GAP_MAX);
  localparam logic signed [GW-1:0] GMIN = GW'(GAP_MIN);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  gdd_adv_t adv;

  assign rdy4 = !v4_r || out_gap.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_dates.ready = rdy1;
  assign adv.ld1 = rdy1;
  assign adv.ld2 = rdy2;
  assign adv.ld3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_dates.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Order the dates by year, month, day
  logic swap_nxt;
  logic swap1_r, swap2_r, swap3_r;

  assign swap_nxt = {in_dates.year_a, in_dates.month_a, in_dates.day_a} >
                    {in_dates.year_b, in_dates.month_b, in_dates.day_b};

  always_ff @(posedge clk) begin
    if (rdy1) swap1_r <= swap_nxt;
    if (rdy2) swap2_r <= swap1_r;
    if (rdy3) swap3_r <= swap2_r;
  end

  logic [OW-1:0] ord_a;
  logic [OW-1:0] ord_b;

  gdd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_ord_a (
    .clk     (clk),
    .adv     (adv),
    .year    (in_dates.year_a),
    .month   (in_dates.month_a),
    .day     (in_dates.day_a),
    .ordinal (ord_a)
  );

  gdd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_ord_b (
    .clk     (clk),
    .adv     (adv),
    .year    (in_dates.year_b),
    .month   (in_dates.month_b),
    .day     (in_dates.day_b),
    .ordinal (ord_b)
  );

  // Stage 4: difference and clamp to the result field
  logic signed [DW-1:0] diff;
  logic signed [GW-1:0] diff_ext;
  logic signed [GW-1:0] clamped;
  gap_t                 gap_nxt, gap_r;

  assign diff     = swap3_r ? $signed({1'b0, ord_a} - {1'b0, ord_b})
                            : $signed({1'b0, ord_b} - {1'b0, ord_a});
  assign diff_ext = GW'(diff);

  always_comb begin
    if (diff_ext > GMAX) begin
      clamped = GMAX;
    end else if (diff_ext < GMIN) begin
      clamped = GMIN;
    end else begin
      clamped = diff_ext;
    end
  end

  assign gap_nxt = GAP_BITS'(clamped);

  always_ff @(posedge clk) begin
    if (rdy4) gap_r <= gap_nxt;
  end

  assign out_gap.valid   = v4_r;
  assign out_gap.day_gap = gap_r;

  `ASSERT_NEXT(a_empty_pipe_latency, clk, rst_n,
    in_dates.valid && in_dates.ready && !v1_r && !v2_r && !v3_r && !v4_r, ##3 v4_r)
  `ASSERT_IMPL(a_gap_floor, clk, rst_n, v4_r, gap_r >= -23'sd31)

endmodule

[hw/rtl/gdd_ordinal.sv]
module gdd_ordinal #(
  parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
  input  logic                   clk,
  input  gdd_pkg::gdd_adv_t      adv,
  input  logic [YEAR_BITS-1:0]   year,
  input  gdd_pkg::month_t        month,
  input  gdd_pkg::day_t          day,
  output logic [YEAR_BITS+8:0]   ordinal
);
  import gdd_pkg::*;

  localparam int N  = YEAR_BITS + 2;
  localparam int S  = N + 7;
  localparam int P  = N + S;
  localparam int CW = N + 7;
  localparam int OW = YEAR_BITS + 9;
  localparam logic [S-1:0] RECIP = S'(((64'd1 << S) + CENTURY - 1) / CENTURY);

  // Stage 1: reciprocal products for the century and quad-century counts
  logic [N-1:0]         x100;
  logic [N-1:0]         x400;
  logic [P-1:0]         prod100_nxt, prod100_r;
  logic [P-1:0]         prod400_nxt, prod400_r;
  logic [YEAR_BITS-1:0] y1_r;
  month_t               m1_r;
  day_t                 d1_r;

  assign x100        = N'(year) + N'(CENTURY - 1);
  assign x400        = (N'(year) + N'(QUAD_CENTURY - 1)) >> 2;
  assign prod100_nxt = P'(x100) * P'(RECIP);
  assign prod400_nxt = P'(x400) * P'(RECIP);

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      prod100_r <= prod100_nxt;
      prod400_r <= prod400_nxt;
      y1_r      <= year;
      m1_r      <= month;
      d1_r      <= day;
    end
  end

  // Stage 2: leap count, leap flag and whole-year days
  logic [N-1:0]  c100;
  logic [N-1:0]  c400;
  logic [N-1:0]  c4;
  logic [CW-1:0] cent_prod;
  logic          century;
  logic [N-1:0]  leaps_nxt, leaps_r;
  logic          leap_nxt, leap_r;
  logic [OW-1:0] y365_nxt, y365_r;
  month_t        m2_r;
  day_t          d2_r;

  assign c100      = prod100_r[S +: N];
  assign c400      = prod400_r[S +: N];
  assign c4        = (N'(y1_r) + N'(3)) >> 2;
  assign cent_prod = CW'(c100) * CW'(CENTURY);
  assign century   = (cent_prod == CW'(y1_r));
  assign leaps_nxt = c4 - c100 + c400;
  assign leap_nxt  = (y1_r[1:0] == 2'b00) && (!century || (c100[1:0] == 2'b00));
  assign y365_nxt  = OW'(y1_r) * OW'(DAYS_COMMON);

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      leaps_r <= leaps_nxt;
      leap_r  <= leap_nxt;
      y365_r  <= y365_nxt;
      m2_r    <= m1_r;
      d2_r    <= d1_r;
    end
  end

  // Stage 3: sum up the ordinal
  logic          leap_day;
  logic [OW-1:0] ord_nxt, ord_r;

  assign leap_day = leap_r && (m2_r > MONTH_FEB);
  assign ord_nxt  = y365_r + OW'(leaps_r) + OW'(days_before_month(m2_r))
                  + OW'(leap_day) + OW'(d2_r);

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      ord_r <= ord_nxt;
    end
  end

  assign ordinal = ord_r;

endmodule

[test/gdd_gap_checker.sv]
module gdd_gap_checker #(
  parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gdd_in_if           in_dates,
  gdd_out_if          out_gap,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  longint month_start [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                               334, 365, 365, 365};

  gap_t        gap_due [$];
  int unsigned fail_total = 0;
  int unsigned held = 0;

  assign mismatches = fail_total;
  assign pending    = held;

  function automatic longint day_number(input longint y, input int unsigned m,
                                        input longint d);
    longint n;
    bit     leap;
    leap = ((y % 4) == 0 && (y % CENTURY) != 0) || (y % QUAD_CENTURY) == 0;
    n = DAYS_COMMON * y + (y + 3) / 4 - (y + 99) / CENTURY + (y + 399) / QUAD_CENTURY;
    n = n + month_start[m] + d;
    if (m > MONTH_FEB && leap) n = n + 1;
    return n;
  endfunction

  function automatic gap_t predict_gap(
    input logic [YEAR_BITS-1:0] ya, input month_t ma, input day_t da,
    input logic [YEAR_BITS-1:0] yb, input month_t mb, input day_t db
  );
    longint first_day;
    longint second_day;
    longint gap;
    first_day  = day_number(longint'(ya), int'(ma), longint'(da));
    second_day = day_number(longint'(yb), int'(mb), longint'(db));
    if ({ya, ma, da} > {yb, mb, db}) gap = first_day - second_day;
    else gap = second_day - first_day;
    if (gap > GAP_MAX) gap = GAP_MAX;
    if (gap < GAP_MIN) gap = GAP_MIN;
    return gap_t'(gap);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("gap check: %s at %0t", what, $realtime);
    fail_total++;
  endtask

  always @(posedge clk) begin : watch
    gap_t want;
    if (rst_n) begin
      if (in_dates.valid && in_dates.ready)
        gap_due.push_back(predict_gap(in_dates.year_a, in_dates.month_a, in_dates.day_a,
                                      in_dates.year_b, in_dates.month_b, in_dates.day_b));
      if (out_gap.valid && out_gap.ready) begin
        if (gap_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected gap %0d", out_gap.day_gap));
        end else begin
          want = gap_due.pop_front();
          if (out_gap.day_gap !== want)
            flag_mismatch($sformatf("gap %0d, want %0d", out_gap.day_gap, want));
        end
      end
      held = gap_due.size();
    end
  end

endmodule

[test/gregorian_date_difference_tb.sv]
module gregorian_date_difference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  localparam int YEAR_BITS    = YEAR_BITS_DEF;
  localparam int ITEMS_PHASE  = 285;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic [YEAR_BITS-1:0] year_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned src_idle_pct = 26;
  int unsigned sink_idle_pct = 79;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  gdd_in_if #(.YEAR_BITS(YEAR_BITS)) in_dates ();
  gdd_out_if                         out_gap ();

  gregorian_date_difference #(.YEAR_BITS(YEAR_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_dates (in_dates),
    .out_gap  (out_gap)
  );

  gdd_gap_checker #(.YEAR_BITS(YEAR_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_dates   (in_dates),
    .out_gap    (out_gap),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_gap.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_gap.ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic offer_dates(input year_t ya, input month_t ma, input day_t da,
                             input year_t yb, input month_t mb, input day_t db);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_dates.valid = 1'b0;
      @(negedge clk);
    end
    in_dates.year_a  = ya;
    in_dates.month_a = ma;
    in_dates.day_a   = da;
    in_dates.year_b  = yb;
    in_dates.month_b = mb;
    in_dates.day_b   = db;
    in_dates.valid   = 1'b1;
    @(posedge clk);
    while (!in_dates.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random_dates();
    year_t       ya, yb;
    month_t      ma, mb;
    day_t        da, db;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    ya = year_t'($urandom_range(1, 9999));
    ma = month_t'($urandom_range(1, 12));
    da = day_t'($urandom_range(1, 31));
    yb = ya;
    mb = ma;
    db = da;
    if (kind < 55) begin
      yb = year_t'($urandom_range(1, 9999));
      mb = month_t'($urandom_range(1, 12));
      db = day_t'($urandom_range(1, 31));
    end else if (kind < 75) begin
      yb = ya + year_t'($urandom_range(0, 1));
      mb = month_t'($urandom_range(1, 12));
      db = day_t'($urandom_range(1, 31));
    end else if (kind < 88) begin
      db = day_t'($urandom_range(0, 31));
    end else begin
      ya = year_t'($urandom);
      ma = month_t'($urandom);
      da = day_t'($urandom);
      yb = year_t'($urandom);
      mb = month_t'($urandom);
      db = day_t'($urandom);
    end
    if ($urandom_range(0, 1)) offer_dates(yb, mb, db, ya, ma, da);
    else offer_dates(ya, ma, da, yb, mb, db);
  endtask

  initial begin
    in_dates.valid   = 1'b0;
    in_dates.year_a  = '0;
    in_dates.month_a = '0;
    in_dates.day_a   = '0;
    in_dates.year_b  = '0;
    in_dates.month_b = '0;
    in_dates.day_b   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    offer_dates(1, 1, 1, 1, 1, 1);
    offer_dates(1, 1, 1, 9999, 12, 31);
    offer_dates(9999, 12, 31, 1, 1, 1);
    offer_dates(0, 0, 0, 16383, 15, 31);
    offer_dates(16383, 15, 31, 0, 0, 0);
    offer_dates(0, 2, 29, 0, 3, 1);
    offer_dates(0, 12, 31, 1, 1, 1);
    offer_dates(2000, 2, 28, 2000, 3, 1);
    offer_dates(1900, 2, 28, 1900, 3, 1);
    offer_dates(2100, 3, 1, 2104, 3, 1);
    offer_dates(2024, 1, 31, 2024, 0, 31);
    offer_dates(2023, 13, 31, 2023, 14, 0);
    offer_dates(2023, 15, 0, 2024, 1, 0);
    offer_dates(2024, 13, 5, 2024, 12, 31);
    offer_dates(2023, 2, 31, 2023, 3, 0);
    offer_dates(5, 6, 0, 5, 6, 31);
    offer_dates(400, 2, 29, 401, 1, 1);
    offer_dates(1582, 10, 15, 2000, 1, 1);
    offer_dates(10000, 1, 1, 16383, 12, 31);
    offer_dates(8191, 7, 16, 8192, 8, 15);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 26;
          sink_idle_pct = 79;
        end
        1: begin
          src_idle_pct  = 79;
          sink_idle_pct = 26;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PHASE) offer_random_dates();
    end

    in_dates.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[gregorian_date_difference.f]
+incdir+hw/rtl
hw/rtl/gdd_pkg.sv
hw/rtl/gdd_in_if.sv
hw/rtl/gdd_out_if.sv
hw/rtl/gdd_ordinal.sv
hw/rtl/gregorian_date_difference.sv
test/gdd_gap_checker.sv
test/gregorian_date_difference_tb.sv
